>>> rtl/vbfp_pkg.sv
// ----------------------------------------------------------------------------
// vbfp_pkg
// Shared types and constants for the camera frame parser.
// ----------------------------------------------------------------------------
package vbfp_pkg;

   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int STATUS_W = 2;
   localparam int NUM_AVG  = 5;   // signature, x, y, width, height

   localparam logic [BYTE_W-1:0] SYNC_LO = 8'h55;
   localparam logic [BYTE_W-1:0] SYNC_HI = 8'hAA;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_SYNC_ERR = 2'd1;
   localparam status_type ST_BAD_BLK1 = 2'd2;
   localparam status_type ST_BAD_BLK2 = 2'd3;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      status_type                status;
      logic [NUM_AVG-1:0][WORD_W-1:0] avg;   // index 0 = signature ... 4 = height
   } rsp_type;

endpackage

>>> rtl/vbfp_skid.sv
// ----------------------------------------------------------------------------
// vbfp_skid
// Two-deep result buffer: output register plus a skid stage.
// ----------------------------------------------------------------------------
module vbfp_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  vbfp_pkg::rsp_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output vbfp_pkg::rsp_type pop_data
);
   import vbfp_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   assign pop        = out_valid_ff & pop_ready;
   assign push_ready = ~skid_valid_ff;
   assign pop_valid  = out_valid_ff;
   assign pop_data   = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         out_valid_in = 1'b1;
         if (!out_valid_ff || pop) begin
            out_data_in = push_data;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

>>> rtl/vision_block_frame_parser.sv
// ----------------------------------------------------------------------------
// vision_block_frame_parser
// Byte-wide sync/checksum parser for camera block frames.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle (a byte is accepted every cycle unless two
// results are waiting unread). A frame is 55 AA then two blocks of 55 AA plus
// BLOCK_WORDS little-endian words (checksum first). Each attempt ends with one
// result: status plus halved sums of the two stored blocks' data words. A
// result is pushed into the output buffer by the byte that ends the attempt;
// the parser state and a running word sum are updated with each accepted byte,
// so the checksum compare at the last byte is a single add and compare.
module vision_block_frame_parser #(
   parameter int BLOCK_WORDS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [vbfp_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [vbfp_pkg::STATUS_W-1:0] rsp_status,
   output logic [vbfp_pkg::WORD_W-1:0]   rsp_signature_average,
   output logic [vbfp_pkg::WORD_W-1:0]   rsp_x_average,
   output logic [vbfp_pkg::WORD_W-1:0]   rsp_y_average,
   output logic [vbfp_pkg::WORD_W-1:0]   rsp_width_average,
   output logic [vbfp_pkg::WORD_W-1:0]   rsp_height_average
);
   import vbfp_pkg::*;

   localparam int POS_W = $clog2(2 * BLOCK_WORDS);
   localparam int IDX_W = $clog2(BLOCK_WORDS);
   localparam int SUM_W = WORD_W + $clog2(BLOCK_WORDS);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(2 * BLOCK_WORDS - 1);

   typedef enum logic [2:0] {
      PH_FRAME_A,
      PH_FRAME_B,
      PH_BLOCK_A,
      PH_BLOCK_B,
      PH_DATA
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic              second_ff, second_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] low_ff, low_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   word_type          left_ff [BLOCK_WORDS];
   word_type          left_in [BLOCK_WORDS];
   word_type          right_ff [BLOCK_WORDS];
   word_type          right_in [BLOCK_WORDS];

   logic              accept;
   logic              has_result;
   status_type        res_status;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   word_type          word;
   word_type          blk0;
   logic [SUM_W-1:0]  sum_total;
   rsp_type           res;
   rsp_type           rsp_data;
   logic              push_ready;

   assign accept    = req_valid & req_ready;
   assign req_ready = push_ready;
   assign word      = {req_rx_byte, low_ff};
   assign wr_idx    = pos_ff[POS_W-1:1];
   assign blk0      = second_ff ? right_ff[0] : left_ff[0];
   assign sum_total = sum_ff + SUM_W'(word);

   always_comb begin
      phase_in   = phase_ff;
      second_in  = second_ff;
      pos_in     = pos_ff;
      low_in     = low_ff;
      sum_in     = sum_ff;
      has_result = 1'b0;
      res_status = ST_OK;
      wr_en      = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_FRAME_A: begin
               if (req_rx_byte != SYNC_LO) begin
                  has_result = 1'b1;
                  res_status = ST_SYNC_ERR;
               end else begin
                  phase_in = PH_FRAME_B;
               end
            end
            PH_FRAME_B: begin
               if (req_rx_byte != SYNC_HI) begin
                  has_result = 1'b1;
                  res_status = ST_SYNC_ERR;
               end else begin
                  phase_in = PH_BLOCK_A;
               end
            end
            PH_BLOCK_A: begin
               if (req_rx_byte != SYNC_LO) begin
                  has_result = 1'b1;
                  res_status = ST_SYNC_ERR;
               end else begin
                  phase_in = PH_BLOCK_B;
               end
            end
            PH_BLOCK_B: begin
               if (req_rx_byte != SYNC_HI) begin
                  has_result = 1'b1;
                  res_status = ST_SYNC_ERR;
               end else begin
                  phase_in = PH_DATA;
                  pos_in   = '0;
                  sum_in   = '0;
               end
            end
            PH_DATA: begin
               if (!pos_ff[0]) begin
                  low_in = req_rx_byte;
               end else begin
                  wr_en = 1'b1;
                  // checksum word itself stays out of the running sum
                  if (wr_idx != '0) begin
                     sum_in = sum_total;
                  end
               end
               pos_in = pos_ff + 1'b1;
               if (pos_ff == LAST_POS) begin
                  pos_in = '0;
                  if (sum_total != SUM_W'(blk0)) begin
                     has_result = 1'b1;
                     res_status = second_ff ? ST_BAD_BLK2 : ST_BAD_BLK1;
                  end else if (second_ff) begin
                     has_result = 1'b1;
                     res_status = ST_OK;
                  end else begin
                     second_in = 1'b1;
                     phase_in  = PH_BLOCK_A;
                  end
               end
            end
            default: begin
               phase_in  = PH_FRAME_A;
               second_in = 1'b0;
               pos_in    = '0;
            end
         endcase
         if (has_result) begin
            phase_in  = PH_FRAME_A;
            second_in = 1'b0;
            pos_in    = '0;
         end
      end
   end

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      if (wr_en) begin
         if (second_ff) begin
            right_in[wr_idx] = word;
         end else begin
            left_in[wr_idx] = word;
         end
      end
   end

   // averages come from the stores as they stand after the ending byte
   assign res.status = res_status;
   for (genvar g = 0; g < NUM_AVG; g++) begin : g_avg
      if (g + 1 < BLOCK_WORDS) begin : g_on
         logic [WORD_W:0] pair_sum;
         assign pair_sum   = {1'b0, left_in[g+1]} + {1'b0, right_in[g+1]};
         assign res.avg[g] = pair_sum[WORD_W:1];
      end else begin : g_off
         assign res.avg[g] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FRAME_A;
         second_ff <= 1'b0;
         pos_ff    <= '0;
         low_ff    <= '0;
         sum_ff    <= '0;
         for (int i = 0; i < BLOCK_WORDS; i++) begin
            left_ff[i]  <= '0;
            right_ff[i] <= '0;
         end
      end else begin
         phase_ff  <= phase_in;
         second_ff <= second_in;
         pos_ff    <= pos_in;
         low_ff    <= low_in;
         sum_ff    <= sum_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
      end
   end

   vbfp_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept & has_result),
      .push_ready (push_ready),
      .push_data  (res),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_data)
   );

   assign rsp_status            = rsp_data.status;
   assign rsp_signature_average = rsp_data.avg[0];
   assign rsp_x_average         = rsp_data.avg[1];
   assign rsp_y_average         = rsp_data.avg[2];
   assign rsp_width_average     = rsp_data.avg[3];
   assign rsp_height_average    = rsp_data.avg[4];

endmodule

>>> rtl/vbfp_checker.sv
// ----------------------------------------------------------------------------
// vbfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module vbfp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [vbfp_pkg::BYTE_W-1:0]   req_rx_byte,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [vbfp_pkg::STATUS_W-1:0] rsp_status,
   input logic [vbfp_pkg::WORD_W-1:0]   rsp_signature_average,
   input logic [vbfp_pkg::WORD_W-1:0]   rsp_height_average
);
   import vbfp_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_signature_average) && $stable(rsp_height_average))
      else $error("result changed while stalled");

   // a new result only follows an accepted byte
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without a transfer in");

   // input only backs up when results are waiting
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // first stray byte after reset is a sync error
   a_hunt: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && req_valid && req_ready && req_rx_byte != SYNC_LO
         |=> rsp_valid && rsp_status == ST_SYNC_ERR)
      else $error("stray byte after reset not reported");

endmodule

bind vision_block_frame_parser vbfp_checker u_vbfp_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_ready             (req_ready),
   .req_rx_byte           (req_rx_byte),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_status            (rsp_status),
   .rsp_signature_average (rsp_signature_average),
   .rsp_height_average    (rsp_height_average)
);
